/* src/dph_pkg.sv */
`timescale 1ns / 1ps
// Package for the descriptor projection hash: beat types, opcodes, register
// indexes, controller states and fixed widths. No dependencies.
package dph_pkg;

  localparam int ACC_W      = 48;
  localparam int COEF_W     = 16;
  localparam int DATA_W     = 16;
  localparam int HASH_W     = 32;
  localparam int DIV_CNT_W  = $clog2(ACC_W);
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int PROJ_REG_W = 3;
  localparam int COLS_REG_W = 8;

  localparam logic [PROJ_REG_W-1:0] ACTIVE_PROJ_RST = 3'd2;
  localparam logic [COLS_REG_W-1:0] ACTIVE_COLS_RST = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_PROJ = 1'b0,
    CFG_ACTIVE_COLS = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ELEM  = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e                  opcode;
    logic [1:0]               proj_index;
    logic [9:0]               row_index;
    logic [6:0]               col_index;
    logic signed [COEF_W-1:0] coefficient;
    logic signed [DATA_W-1:0] descriptor_value;
  } in_t;

  typedef struct packed {
    logic signed [HASH_W-1:0] hash_value;
    logic                     no_rows;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ELEM,
    ST_RDWAIT,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_e;

endpackage

/* src/dph_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/descriptor_projection_hash.sv */
`timescale 1ns / 1ps
// Descriptor projection hash. Element beat: one accumulator read-modify-write
// per cycle for each of the P active projections, P the active projection count,
// through the accumulator RAM pipeline. Read beat: runs the 48-step bit-serial
// divider; a read that fails its checks skips the divider and gives zero.
// Reset and clear beats run a sweep over all MAX_PROJ * MAX_COLS entries that zeroes
// the accumulator RAM; no beat is taken meanwhile, configuration writes are.
// Uses dph_pkg and dph_ram.
module descriptor_projection_hash
  import dph_pkg::*;
#(
  parameter int MAX_PROJ = 4,
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  localparam int CoefDepth = MAX_PROJ * MAX_ROWS;
  localparam int AccDepth  = MAX_PROJ * MAX_COLS;
  localparam int CAW = (CoefDepth > 1) ? $clog2(CoefDepth) : 1;
  localparam int AAW = (AccDepth > 1) ? $clog2(AccDepth) : 1;
  localparam int PCW = $clog2(MAX_PROJ + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  state_e state_q, state_d;

  logic [PROJ_REG_W-1:0] active_proj_q;
  logic [COLS_REG_W-1:0] active_cols_q;
  logic [PCW-1:0]        used_proj;
  logic [CCW-1:0]        used_cols;

  logic [RCW-1:0] row_count_q;
  logic [RCW-1:0] row_p1;
  logic [AAW-1:0] clr_q;
  logic           clr_last;

  logic in_accept;
  logic elem_ok;
  logic load_ok;
  logic read_ok;

  // Element pipeline: issue coefficient read, multiply, accumulate and write.
  logic                     issuing_q;
  logic [PCW-1:0]           p_cnt_q;
  logic                     v1_q, v2_q;
  logic [PCW-1:0]           p1_q;
  logic [AAW-1:0]           a2_q;
  logic [9:0]               row_q;
  logic [6:0]               col_q;
  logic signed [DATA_W-1:0] d_q;
  logic signed [2*COEF_W-1:0] prod_q;

  logic              coef_we;
  logic [CAW-1:0]    coef_waddr;
  logic [CAW-1:0]    coef_raddr;
  logic [COEF_W-1:0] coef_rdata;

  logic             acc_we;
  logic [AAW-1:0]   acc_waddr;
  logic [ACC_W-1:0] acc_wdata;
  logic [AAW-1:0]   acc_raddr;
  logic [AAW-1:0]   acc_s1_addr;
  logic [AAW-1:0]   acc_rd_addr_in;
  logic [ACC_W-1:0] acc_rdata;
  logic [ACC_W-1:0] acc_sum;

  // Divider and result.
  logic [ACC_W-1:0]     quo_q;
  logic [RCW-1:0]       rem_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [RCW:0]         trial;
  logic                 trial_ge;
  logic [HASH_W-1:0]    sat_value;
  out_t                 res_q;
  out_t                 out_q;
  logic                 out_valid_q;
  logic                 out_free;

  // Register values are used clamped to the supported range.
  always_comb begin
    if (active_proj_q == '0) begin
      used_proj = PCW'(1);
    end else if (active_proj_q > MAX_PROJ) begin
      used_proj = PCW'(MAX_PROJ);
    end else begin
      used_proj = PCW'(active_proj_q);
    end
    if (active_cols_q == '0) begin
      used_cols = CCW'(1);
    end else if (active_cols_q > MAX_COLS) begin
      used_cols = CCW'(MAX_COLS);
    end else begin
      used_cols = CCW'(active_cols_q);
    end
  end

  assign in_accept = in_valid_i && in_ready_o;
  assign load_ok   = (in_data_i.proj_index < MAX_PROJ) && (in_data_i.row_index < MAX_ROWS);
  assign elem_ok   = (in_data_i.row_index < MAX_ROWS) && (in_data_i.col_index < used_cols);
  assign read_ok   = (row_count_q != '0) && (in_data_i.proj_index < used_proj) &&
                     (in_data_i.col_index < used_cols);
  assign row_p1    = RCW'(in_data_i.row_index) + RCW'(1);
  assign clr_last  = (clr_q == AAW'(AccDepth - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  assign coef_waddr = CAW'(in_data_i.proj_index) * CAW'(MAX_ROWS) + CAW'(in_data_i.row_index);
  assign coef_raddr = CAW'(p_cnt_q) * CAW'(MAX_ROWS) + CAW'(row_q);
  assign acc_s1_addr    = AAW'(p1_q) * AAW'(MAX_COLS) + AAW'(col_q);
  assign acc_rd_addr_in = AAW'(in_data_i.proj_index) * AAW'(MAX_COLS) +
                          AAW'(in_data_i.col_index);
  assign acc_sum = acc_rdata + {{(ACC_W - 2*COEF_W){prod_q[2*COEF_W-1]}}, prod_q};

  assign trial    = {rem_q, quo_q[ACC_W-1]};
  assign trial_ge = (trial >= {1'b0, row_count_q});

  always_comb begin
    if (!neg_q) begin
      if (quo_q > ACC_W'(32'h7FFF_FFFF)) begin
        sat_value = 32'h7FFF_FFFF;
      end else begin
        sat_value = quo_q[HASH_W-1:0];
      end
    end else begin
      if (quo_q > ACC_W'(32'h8000_0000)) begin
        sat_value = 32'h8000_0000;
      end else begin
        sat_value = ~quo_q[HASH_W-1:0] + HASH_W'(1);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data_i.opcode)
            OP_CLEAR: state_d = ST_CLEAR;
            OP_LOAD:  state_d = ST_IDLE;
            OP_ELEM:  state_d = elem_ok ? ST_ELEM : ST_IDLE;
            OP_READ:  state_d = read_ok ? ST_RDWAIT : ST_OUT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ELEM: begin
        if (!issuing_q && !v1_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_RDWAIT: state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(ACC_W - 1)) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory port controls.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    coef_we    = in_accept && (in_data_i.opcode == OP_LOAD) && load_ok;
    acc_raddr  = (state_q == ST_IDLE) ? acc_rd_addr_in : acc_s1_addr;
    if (state_q == ST_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_q;
      acc_wdata = '0;
    end else begin
      acc_we    = v2_q;
      acc_waddr = a2_q;
      acc_wdata = acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      active_proj_q <= ACTIVE_PROJ_RST;
      active_cols_q <= ACTIVE_COLS_RST;
      row_count_q   <= '0;
      clr_q         <= '0;
      issuing_q     <= 1'b0;
      p_cnt_q       <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ACTIVE_PROJ) begin
          active_proj_q <= cfg_data_i[PROJ_REG_W-1:0];
        end else begin
          active_cols_q <= cfg_data_i[COLS_REG_W-1:0];
        end
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AAW'(1);
      end
      if (in_accept && (in_data_i.opcode == OP_CLEAR)) begin
        row_count_q <= '0;
        clr_q       <= '0;
      end
      if (in_accept && (in_data_i.opcode == OP_ELEM) && elem_ok) begin
        issuing_q <= 1'b1;
        p_cnt_q   <= '0;
        if (row_p1 > row_count_q) begin
          row_count_q <= row_p1;
        end
      end else if (issuing_q) begin
        p_cnt_q <= p_cnt_q + PCW'(1);
        if (p_cnt_q == used_proj - PCW'(1)) begin
          issuing_q <= 1'b0;
        end
      end
      v1_q <= issuing_q;
      v2_q <= v1_q;
      if (state_q == ST_RDWAIT) begin
        div_cnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      row_q <= in_data_i.row_index;
      col_q <= in_data_i.col_index;
      d_q   <= in_data_i.descriptor_value;
    end
    if (in_accept && (in_data_i.opcode == OP_READ)) begin
      res_q.no_rows    <= (row_count_q == '0);
      res_q.hash_value <= '0;
    end
    p1_q   <= p_cnt_q;
    a2_q   <= acc_s1_addr;
    prod_q <= $signed(coef_rdata) * d_q;
    if (state_q == ST_RDWAIT) begin
      // Divide the magnitude; the sign is put back after the last step.
      neg_q <= acc_rdata[ACC_W-1];
      quo_q <= acc_rdata[ACC_W-1] ? (~acc_rdata + ACC_W'(1)) : acc_rdata;
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      quo_q <= {quo_q[ACC_W-2:0], trial_ge};
      rem_q <= trial_ge ? RCW'(trial - {1'b0, row_count_q}) : RCW'(trial);
    end
    if (state_q == ST_FIX) begin
      res_q.hash_value <= sat_value;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  dph_ram #(
    .WIDTH (COEF_W),
    .DEPTH (CoefDepth)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_data_i.coefficient),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  dph_ram #(
    .WIDTH (ACC_W),
    .DEPTH (AccDepth)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

endmodule
